// ----- rtl/core/klvls_pkg.sv -----
// Shared types, codes and constants of the KLV local set parser.
package klvls_pkg;

  localparam int unsigned LengthBitsDefault = 32;
  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned TagShift          = 3;
  localparam int unsigned LenShift          = 5;
  localparam int unsigned BerMaxOctets      = 4;

  typedef enum logic [1:0] {
    TC_ONE  = 2'd0,
    TC_BER  = 2'd1,
    TC_TWO  = 2'd2,
    TC_FOUR = 2'd3
  } tag_coding_e;

  typedef enum logic [1:0] {
    LC_BER  = 2'd0,
    LC_ONE  = 2'd1,
    LC_TWO  = 2'd2,
    LC_FOUR = 2'd3
  } len_coding_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_TRUNC = 2'd0,
    ERR_INDEF = 2'd1,
    ERR_LONG  = 2'd2
  } err_e;

  // One classified input byte.
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    tag_coding_e tag_coding;
    len_coding_e len_coding;
    logic        ber_short;
    logic        ber_indef;
    logic        ber_long;
    logic [2:0]  ber_count;
  } cls_t;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] tag;
    logic [31:0] length;
    logic [7:0]  value;
    logic        value_end;
    logic        set_end;
    err_e        error_code;
  } res_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ----- rtl/core/klvls_classify.sv -----
// Byte classifier: decodes the designator and the BER class of each byte.
module klvls_classify
  import klvls_pkg::*;
(
  input  logic [7:0] data_byte_i,
  input  logic       set_first_i,
  input  logic       set_last_i,
  input  logic [7:0] designator_i,
  output cls_t       cls_o
);

  always_comb begin
    cls_o.data       = data_byte_i;
    cls_o.first      = set_first_i;
    cls_o.last       = set_last_i;
    cls_o.tag_coding = tag_coding_e'(designator_i[TagShift +: 2]);
    cls_o.len_coding = len_coding_e'(designator_i[LenShift +: 2]);
    cls_o.ber_short  = ~data_byte_i[7];
    cls_o.ber_indef  = (data_byte_i == 8'h80);
    cls_o.ber_long   = data_byte_i[7] && (data_byte_i[6:0] > 7'(BerMaxOctets));
    cls_o.ber_count  = data_byte_i[2:0];
  end

endmodule

// ----- rtl/core/klvls_queue.sv -----
// Short queue of classified bytes between the front and the parser.
module klvls_queue
  import klvls_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cls_t    wdata_i,
  input  logic    pop_i,
  output cls_t    head_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cls_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(DEPTH));

endmodule

// ----- rtl/core/klvls_exec.sv -----
// Parser: walks tag, length and value fields and registers the result item.
module klvls_exec
  import klvls_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cls_t head_i,
  input  logic avail_i,
  output logic pop_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output res_t res_o
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_TAG   = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_VALUE = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    FR_PEND  = 2'd0,
    FR_DONE  = 2'd1,
    FR_INDEF = 2'd2,
    FR_LONG  = 2'd3
  } feed_res_e;

  typedef struct packed {
    logic [31:0] acc;
    logic [2:0]  fleft;
    feed_res_e   res;
  } feed_t;

  localparam logic [31:0] LenMax =
    (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << LENGTH_BITS) - 64'd1);

  function automatic logic [2:0] tag_size(input tag_coding_e c);
    logic [2:0] s;
    unique case (c)
      TC_ONE:  s = 3'd1;
      TC_BER:  s = 3'd0;
      TC_TWO:  s = 3'd2;
      TC_FOUR: s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] len_size(input len_coding_e c);
    logic [2:0] s;
    unique case (c)
      LC_BER:  s = 3'd0;
      LC_ONE:  s = 3'd1;
      LC_TWO:  s = 3'd2;
      LC_FOUR: s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // One byte of a tag or length field.
  function automatic feed_t feed(input logic [31:0] acc, input logic [2:0] fleft,
                                 input logic ber, input cls_t c);
    feed_t f;
    f.acc   = acc;
    f.fleft = fleft;
    f.res   = FR_PEND;
    if (ber && fleft == 3'd0) begin
      if (c.ber_short) begin
        f.acc = {24'd0, c.data};
        f.res = FR_DONE;
      end else if (c.ber_indef) begin
        f.res = FR_INDEF;
      end else if (c.ber_long) begin
        f.res = FR_LONG;
      end else begin
        f.fleft = c.ber_count;
        f.acc   = '0;
      end
    end else begin
      f.acc = {acc[23:0], c.data};
      if (fleft != 3'd0) begin
        f.fleft = fleft - 3'd1;
      end
      f.res = (f.fleft == 3'd0) ? FR_DONE : FR_PEND;
    end
    return f;
  endfunction

  phase_e               phase_q, phase_d;
  tag_coding_e          tcod_q, tcod_d;
  len_coding_e          lcod_q, lcod_d;
  logic [2:0]           fleft_q, fleft_d;
  logic [31:0]          tacc_q, tacc_d;
  logic [31:0]          lacc_q, lacc_d;
  logic [LENGTH_BITS-1:0] vleft_q, vleft_d;
  logic                 out_valid_q, out_valid_d;
  res_t                 out_q, res;
  logic                 emit;
  logic                 pop;

  assign pop   = avail_i && (!out_valid_q || out_ready_i);
  assign pop_o = pop;

  always_comb begin
    feed_t fr;
    logic  tag_ph;
    logic  vend;
    phase_d = phase_q;
    tcod_d  = tcod_q;
    lcod_d  = lcod_q;
    fleft_d = fleft_q;
    tacc_d  = tacc_q;
    lacc_d  = lacc_q;
    vleft_d = vleft_q;
    emit    = 1'b0;
    res     = '0;
    fr      = '0;
    tag_ph  = 1'b0;
    vend    = 1'b0;
    if (pop) begin
      if (head_i.first) begin
        tcod_d  = head_i.tag_coding;
        lcod_d  = head_i.len_coding;
        tacc_d  = '0;
        lacc_d  = '0;
        vleft_d = '0;
        phase_d = PH_TAG;
        fleft_d = tag_size(head_i.tag_coding);
      end
      if (head_i.first || phase_q != PH_IDLE) begin
        if (phase_d == PH_VALUE) begin
          vleft_d    = vleft_d - LENGTH_BITS'(vleft_d != '0);
          vend       = (vleft_d == '0);
          emit       = 1'b1;
          res.tag    = tacc_d;
          res.length = lacc_d;
          if (head_i.last && !vend) begin
            res.kind    = KIND_ERROR;
            res.set_end = 1'b1;
            phase_d     = PH_IDLE;
          end else begin
            res.kind      = KIND_VALUE;
            res.value     = head_i.data;
            res.value_end = vend;
            res.set_end   = head_i.last;
            if (head_i.last) begin
              phase_d = PH_IDLE;
            end else if (vend) begin
              tacc_d  = '0;
              lacc_d  = '0;
              vleft_d = '0;
              phase_d = PH_TAG;
              fleft_d = tag_size(tcod_d);
            end
          end
        end else begin
          tag_ph = (phase_d == PH_TAG);
          fr = feed(tag_ph ? tacc_d : lacc_d, fleft_d,
                    tag_ph ? (tcod_d == TC_BER) : (lcod_d == LC_BER), head_i);
          if (tag_ph) begin
            tacc_d = fr.acc;
          end else begin
            lacc_d = fr.acc;
          end
          fleft_d = fr.fleft;
          if (fr.res == FR_INDEF || fr.res == FR_LONG) begin
            emit           = 1'b1;
            res.kind       = KIND_ERROR;
            res.tag        = tacc_d;
            res.length     = lacc_d;
            res.set_end    = head_i.last;
            res.error_code = (fr.res == FR_INDEF) ? ERR_INDEF : ERR_LONG;
            phase_d        = PH_IDLE;
          end else if (fr.res == FR_PEND || tag_ph) begin
            if (fr.res == FR_DONE) begin
              phase_d = PH_LEN;
              fleft_d = len_size(lcod_d);
            end
            if (head_i.last) begin
              emit        = 1'b1;
              res.kind    = KIND_ERROR;
              res.tag     = tacc_d;
              res.length  = lacc_d;
              res.set_end = 1'b1;
              phase_d     = PH_IDLE;
            end
          end else begin
            // Length complete: clamp; emit header or truncation error.
            if (lacc_d > LenMax) begin
              lacc_d = LenMax;
            end
            vleft_d    = LENGTH_BITS'(lacc_d);
            emit       = 1'b1;
            res.tag    = tacc_d;
            res.length = lacc_d;
            if (lacc_d == '0) begin
              res.kind      = KIND_HEADER;
              res.value_end = 1'b1;
              res.set_end   = head_i.last;
              if (head_i.last) begin
                phase_d = PH_IDLE;
              end else begin
                tacc_d  = '0;
                lacc_d  = '0;
                vleft_d = '0;
                phase_d = PH_TAG;
                fleft_d = tag_size(tcod_d);
              end
            end else if (head_i.last) begin
              res.kind    = KIND_ERROR;
              res.set_end = 1'b1;
              phase_d     = PH_IDLE;
            end else begin
              res.kind = KIND_HEADER;
              phase_d  = PH_VALUE;
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tcod_q      <= TC_ONE;
      lcod_q      <= LC_BER;
      fleft_q     <= '0;
      tacc_q      <= '0;
      lacc_q      <= '0;
      vleft_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tcod_q      <= tcod_d;
      lcod_q      <= lcod_d;
      fleft_q     <= fleft_d;
      tacc_q      <= tacc_d;
      lacc_q      <= lacc_d;
      vleft_q     <= vleft_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ----- rtl/core/klv_local_set_parser.sv -----
// KLV local set parser top level: byte classifier, queue and field parser.
//
// Takes the value bytes of one local set, one byte per item, and splits them
// into tag / length / value items. The designator byte sampled with
// set_first_i picks the tag coding (bits 4:3: one byte, BER, two bytes, four
// bytes) and the length coding (bits 6:5: BER, one, two or four bytes); all
// multi-byte fields are big-endian. Each item gives a header result (kind 0)
// carrying tag and length, then one result per value byte (kind 1), the last
// one flagged by value_end_o; a header of length zero carries value_end_o
// itself. Tag bytes and non-final length bytes give no result. A set that
// ends inside a field or value gives an error result (kind 2, code 0) with
// set_end_o high; a BER indefinite form (code 1) or a BER count above four
// (code 2) gives an error, and bytes are then dropped until the next
// set_first_i. Bytes outside a set are dropped; a new set_first_i abandons
// an open set silently. Decoded lengths above the largest LENGTH_BITS-bit
// value are clamped to it. The block sustains one byte per clock: the
// parser retires one queued byte per cycle whenever its output register is
// free or being emptied. A result is registered: its byte is written into
// the queue when accepted, then parsed into the output register once it
// reaches the head of the queue and the parser may retire it. The queue
// of QUEUE_DEPTH items absorbs stalls on the result side; in_ready_o drops
// only while it is full. No clearing pass after reset.
module klv_local_set_parser
  import klvls_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        set_first_i,
  input  logic        set_last_i,
  input  logic [7:0]  designator_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] item_tag_o,
  output logic [31:0] item_length_o,
  output logic [7:0]  value_out_o,
  output logic        value_end_o,
  output logic        set_end_o,
  output logic [1:0]  error_code_o
);

  cls_t    cls;
  cls_t    head;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  res_t    res;

  // Front: classify each byte as it arrives.
  klvls_classify u_classify (
    .data_byte_i  (data_byte_i),
    .set_first_i  (set_first_i),
    .set_last_i   (set_last_i),
    .designator_i (designator_i),
    .cls_o        (cls)
  );

  // Accept whenever the queue has room, independent of the result side.
  assign in_ready_o = ~q_stat.full;
  assign push       = in_valid_i & in_ready_o;

  klvls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cls),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  // Back: walk the fields and hold the result until it is taken.
  klvls_exec #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .avail_i     (~q_stat.empty),
    .pop_o       (pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign kind_o        = res.kind;
  assign item_tag_o    = res.tag;
  assign item_length_o = res.length;
  assign value_out_o   = res.value;
  assign value_end_o   = res.value_end;
  assign set_end_o     = res.set_end;
  assign error_code_o  = res.error_code;

`ifndef SYNTHESIS
  // Error codes other than truncation only travel with error items.
  a_code_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_ERROR) |-> (error_code_o == ERR_TRUNC))
    else $error("error code set on a non-error item");

  // Value byte is zero unless the item carries a value byte.
  a_value_only_on_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_VALUE) |-> (value_out_o == 8'd0))
    else $error("value byte set on a non-value item");

  // A header may close the set only when its value is empty.
  a_header_close_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_HEADER) && set_end_o |-> value_end_o)
    else $error("set closed on a header with a pending value");

  // Error items never mark the end of a value.
  a_error_no_value_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ERROR) |-> !value_end_o)
    else $error("value end flagged on an error item");
`endif

endmodule

// ----- tb/klv_local_set_parser_checker.sv -----
// Result checker for the KLV local set parser: byte-level predictor and scoreboard.
module klv_local_set_parser_checker
  import klvls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        set_first_i,
  input  logic        set_last_i,
  input  logic [7:0]  designator_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] item_tag_i,
  input  logic [31:0] item_length_i,
  input  logic [7:0]  value_out_i,
  input  logic        value_end_i,
  input  logic        set_end_i,
  input  logic [1:0]  error_code_i,
  output int unsigned mismatches_o,
  output int unsigned expected_left_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {PH_IDLE, PH_TAG, PH_LEN, PH_VALUE} split_phase_e;
  typedef enum logic [1:0] {FS_PENDING, FS_DONE, FS_INDEF, FS_LONG} field_state_e;

  // Largest length the block can carry; anything above is clamped to it.
  localparam logic [63:0] LenCap = (LengthBitsDefault >= 64) ? '1 :
                                   (64'd1 << LengthBitsDefault) - 64'd1;

  split_phase_e phase;
  tag_coding_e  tag_code;
  len_coding_e  len_code;
  logic [2:0]   field_left;
  logic [31:0]  tag_acc;
  logic [31:0]  len_acc;
  logic [31:0]  value_left;
  res_t         results_due[$];
  res_t         want;
  int unsigned  mismatches;

  assign mismatches_o    = mismatches;
  assign expected_left_o = results_due.size();

  function automatic logic [2:0] tag_bytes(input tag_coding_e c);
    case (c)
      TC_ONE:  return 3'd1;
      TC_TWO:  return 3'd2;
      TC_FOUR: return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] len_bytes(input len_coding_e c);
    case (c)
      LC_ONE:  return 3'd1;
      LC_TWO:  return 3'd2;
      LC_FOUR: return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  function automatic void open_item();
    tag_acc    = '0;
    len_acc    = '0;
    value_left = '0;
    phase      = PH_TAG;
    field_left = tag_bytes(tag_code);
  endfunction

  // Error code reads zero outside error results, hence ERR_TRUNC as filler.
  function automatic void expect_result(input kind_e k, input logic [7:0] v,
                                        input logic vend, input logic send,
                                        input err_e code);
    res_t r;
    r.kind       = k;
    r.tag        = tag_acc;
    r.length     = len_acc;
    r.value      = v;
    r.value_end  = vend;
    r.set_end    = send;
    r.error_code = code;
    results_due = {results_due, r};
  endfunction

  // Shift one byte into a tag or length field; BER fields open with a short-form value or a count byte.
  function automatic field_state_e feed_field(inout logic [31:0] acc, input logic ber,
                                              input logic [7:0] d);
    if (ber && field_left == 3'd0) begin
      if (d < 8'h80) begin
        acc = {24'd0, d};
        return FS_DONE;
      end
      if (d == 8'h80) return FS_INDEF;
      if (d[6:0] > 7'(BerMaxOctets)) return FS_LONG;
      field_left = d[2:0];
      acc = '0;
      return FS_PENDING;
    end
    acc = {acc[23:0], d};
    if (field_left != 3'd0) field_left--;
    return (field_left == 3'd0) ? FS_DONE : FS_PENDING;
  endfunction

  task automatic split_byte(input logic [7:0] d, input logic first, input logic last,
                            input logic [7:0] des);
    field_state_e st;
    logic         vend;
    if (first) begin
      tag_code = tag_coding_e'(des[TagShift +: 2]);
      len_code = len_coding_e'(des[LenShift +: 2]);
      open_item();
    end else if (phase == PH_IDLE) begin
      return;
    end

    if (phase == PH_VALUE) begin
      if (value_left != 0) value_left--;
      vend = (value_left == 0);
      if (last && !vend) begin
        expect_result(KIND_ERROR, 8'd0, 1'b0, 1'b1, ERR_TRUNC);
        phase = PH_IDLE;
        return;
      end
      expect_result(KIND_VALUE, d, vend, last, ERR_TRUNC);
      if (last) phase = PH_IDLE;
      else if (vend) open_item();
      return;
    end

    if (phase == PH_TAG) st = feed_field(tag_acc, tag_code == TC_BER, d);
    else                 st = feed_field(len_acc, len_code == LC_BER, d);

    if (st == FS_INDEF || st == FS_LONG) begin
      expect_result(KIND_ERROR, 8'd0, 1'b0, last, (st == FS_INDEF) ? ERR_INDEF : ERR_LONG);
      phase = PH_IDLE;
      return;
    end
    if (st == FS_PENDING || phase == PH_TAG) begin
      if (st == FS_DONE) begin
        phase      = PH_LEN;
        field_left = len_bytes(len_code);
      end
      if (last) begin
        expect_result(KIND_ERROR, 8'd0, 1'b0, 1'b1, ERR_TRUNC);
        phase = PH_IDLE;
      end
      return;
    end

    // length complete: clamp, then header, zero-length item or truncation error
    if ({32'd0, len_acc} > LenCap) len_acc = LenCap[31:0];
    value_left = len_acc;
    if (value_left == 0) begin
      expect_result(KIND_HEADER, 8'd0, 1'b1, last, ERR_TRUNC);
      if (last) phase = PH_IDLE;
      else open_item();
      return;
    end
    if (last) begin
      expect_result(KIND_ERROR, 8'd0, 1'b0, 1'b1, ERR_TRUNC);
      phase = PH_IDLE;
      return;
    end
    expect_result(KIND_HEADER, 8'd0, 1'b0, 1'b0, ERR_TRUNC);
    phase = PH_VALUE;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, exp_val));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase      = PH_IDLE;
      tag_code   = TC_ONE;
      len_code   = LC_BER;
      field_left = '0;
      tag_acc    = '0;
      len_acc    = '0;
      value_left = '0;
      mismatches = 0;
      results_due.delete();
    end else begin
      // compare first, so a spurious result never meets this edge's prediction
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result, kind %0d", kind_i));
        end else begin
          want = results_due.pop_front();
          check_field("kind", 32'(kind_i), 32'(want.kind));
          check_field("item_tag", item_tag_i, want.tag);
          check_field("item_length", item_length_i, want.length);
          check_field("value_out", 32'(value_out_i), 32'(want.value));
          check_field("value_end", 32'(value_end_i), 32'(want.value_end));
          check_field("set_end", 32'(set_end_i), 32'(want.set_end));
          check_field("error_code", 32'(error_code_i), 32'(want.error_code));
        end
      end
      if (in_valid_i && in_ready_i)
        split_byte(data_byte_i, set_first_i, set_last_i, designator_i);
    end
  end

endmodule

// ----- tb/klv_local_set_parser_tb.sv -----
// Testbench top for the KLV local set parser: stimulus, flow control and verdict.
module klv_local_set_parser_tb
  import klvls_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        set_first;
  logic        set_last;
  logic [7:0]  designator;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [31:0] item_tag;
  logic [31:0] item_length;
  logic [7:0]  value_out;
  logic        value_end;
  logic        set_end;
  logic [1:0]  error_code;
  int unsigned mismatches;
  int unsigned expected_left;

  // flow control knobs, changed per phase by the stimulus
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_kick;
  int unsigned hold_left;

  // bytes of the set being built, and how many set bytes have gone in
  logic [7:0]  set_bytes[$];
  int unsigned sent_in_sets;

  int unsigned send_pct[5] = '{0, 46, 0, 28, 0};
  int unsigned recv_pct[5] = '{0, 0, 46, 28, 0};

  klv_local_set_parser dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_i  (data_byte),
    .set_first_i  (set_first),
    .set_last_i   (set_last),
    .designator_i (designator),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .kind_o       (kind),
    .item_tag_o   (item_tag),
    .item_length_o(item_length),
    .value_out_o  (value_out),
    .value_end_o  (value_end),
    .set_end_o    (set_end),
    .error_code_o (error_code)
  );

  klv_local_set_parser_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .data_byte_i    (data_byte),
    .set_first_i    (set_first),
    .set_last_i     (set_last),
    .designator_i   (designator),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .kind_i         (kind),
    .item_tag_i     (item_tag),
    .item_length_i  (item_length),
    .value_out_i    (value_out),
    .value_end_i    (value_end),
    .set_end_i      (set_end),
    .error_code_i   (error_code),
    .mismatches_o   (mismatches),
    .expected_left_o(expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request so the
  // internal queue fills and the input side has to back off.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_kick) begin
        hold_kick = 1'b0;
        hold_left = 79;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Generous ceiling on the whole run.
  initial begin
    #2000000;
    $display("klv_local_set_parser_tb: done, errors");
    $finish;
  end

  // Offer one item and hold it until it is taken; idle gaps come first so
  // valid never drops once raised.
  task automatic send_byte(input logic [7:0] d, input logic first, input logic last,
                           input logic [7:0] des);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= d;
    set_first  <= first;
    set_last   <= last;
    designator <= des;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send the first n bytes of set_bytes; close the set only when asked.
  task automatic send_set(input logic [7:0] des, input int unsigned n, input logic closed);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      send_byte(set_bytes[i], i == 0, closed && (i == n - 1),
                (i == 0) ? des : 8'($urandom));
      sent_in_sets++;
    end
  endtask

  // Designator with the chosen codings and random bits elsewhere.
  function automatic logic [7:0] make_des(input tag_coding_e tc, input len_coding_e lc);
    logic [7:0] d;
    d = 8'($urandom);
    d[TagShift +: 2] = tc;
    d[LenShift +: 2] = lc;
    return d;
  endfunction

  // Append one byte to the set being built.
  function automatic void add_byte(input logic [7:0] b);
    set_bytes = {set_bytes, b};
  endfunction

  function automatic void push_be(input logic [31:0] v, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endfunction

  // BER: short form when it fits and the coin says so, else long form with
  // a count of at least the bytes needed (leading zeros allowed).
  function automatic void push_ber(input logic [31:0] v);
    int need;
    if (v < 32'h80 && $urandom_range(0, 1) == 1) begin
      add_byte(v[7:0]);
      return;
    end
    need = (v > 32'hFFFFFF) ? 4 : (v > 32'hFFFF) ? 3 : (v > 32'hFF) ? 2 : 1;
    need = $urandom_range(need, BerMaxOctets);
    add_byte(8'h80 | 8'(need));
    push_be(v, need);
  endfunction

  // Broken BER opener (indefinite or over-long count), then some bytes to drop.
  function automatic void push_bad_ber();
    add_byte(($urandom_range(0, 1) == 1) ? 8'h80 : 8'($urandom_range(8'h85, 8'hFF)));
    repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
  endfunction

  // Build a set of one to four items, well-formed unless a huge length cuts it
  // short; spoil breaks the first BER field of the final item.
  task automatic build_set(input tag_coding_e tc, input len_coding_e lc, input logic spoil);
    int unsigned n_items;
    int unsigned k;
    logic        spoil_now;
    logic [31:0] tag;
    logic [31:0] len;
    set_bytes.delete();
    n_items = $urandom_range(1, 4);
    for (k = 0; k < n_items; k++) begin
      spoil_now = spoil && (k == n_items - 1);
      tag = $urandom >> $urandom_range(0, 31);
      case (tc)
        TC_ONE:  push_be(tag, 1);
        TC_TWO:  push_be(tag, 2);
        TC_FOUR: push_be(tag, 4);
        default: begin
          if (spoil_now) begin
            push_bad_ber();
            return;
          end
          push_ber(tag);
        end
      endcase

      len = ($urandom_range(0, 19) == 0) ? ($urandom >> $urandom_range(0, 12))
                                        : 32'($urandom_range(0, 6));
      case (lc)
        LC_ONE:  begin len &= 32'hFF;   push_be(len, 1); end
        LC_TWO:  begin len &= 32'hFFFF; push_be(len, 2); end
        LC_FOUR: push_be(len, 4);
        default: begin
          if (spoil_now) begin
            push_bad_ber();
            return;
          end
          push_ber(len);
        end
      endcase

      // huge value: send a few bytes and let the set end inside it
      if (len > 40) begin
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
        return;
      end
      repeat (len) add_byte(8'($urandom));
    end
  endtask

  // One random stimulus unit: mostly clean sets, some truncated, broken,
  // abandoned, and stray bytes between sets.
  task automatic random_set();
    int unsigned pick;
    tag_coding_e tc;
    len_coding_e lc;
    pick = $urandom_range(0, 99);
    tc   = tag_coding_e'($urandom_range(0, 3));
    lc   = len_coding_e'($urandom_range(0, 3));
    if (pick < 70) begin
      build_set(tc, lc, 1'b0);
      send_set(make_des(tc, lc), set_bytes.size(), 1'b1);
    end else if (pick < 80) begin
      build_set(tc, lc, 1'b0);
      send_set(make_des(tc, lc), $urandom_range(1, set_bytes.size()), 1'b1);
    end else if (pick < 88) begin
      if (tc != TC_BER && lc != LC_BER) lc = LC_BER;
      build_set(tc, lc, 1'b1);
      send_set(make_des(tc, lc), set_bytes.size(), 1'b1);
    end else if (pick < 94) begin
      build_set(tc, lc, 1'b0);
      send_set(make_des(tc, lc), $urandom_range(1, set_bytes.size()), 1'b0);
    end else begin
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom), 1'b0, 1'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int unsigned ph;
    int unsigned stop_at;
    int unsigned waited;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    data_byte      = 8'd0;
    set_first      = 1'b0;
    set_last       = 1'b0;
    designator     = 8'd0;
    hold_kick      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sent_in_sets   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero-length header then a two-byte value, all single bytes.
    set_bytes = '{8'h00, 8'h00, 8'hFF, 8'h02, 8'h00, 8'hFF};
    send_set(make_des(TC_ONE, LC_ONE), set_bytes.size(), 1'b1);
    // Widest tag and length, set closes one byte into the value.
    set_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAB};
    send_set(make_des(TC_FOUR, LC_FOUR), set_bytes.size(), 1'b1);
    // Indefinite BER tag, then a byte to drop.
    set_bytes = '{8'h80, 8'h5A};
    send_set(make_des(TC_BER, LC_BER), set_bytes.size(), 1'b1);
    // Over-long BER length on the closing byte.
    set_bytes = '{8'h7F, 8'h85};
    send_set(make_des(TC_BER, LC_BER), set_bytes.size(), 1'b1);
    // Two-byte tag, BER long-form length of one.
    set_bytes = '{8'h12, 8'h34, 8'h81, 8'h01, 8'h5A};
    send_set(make_des(TC_TWO, LC_BER), set_bytes.size(), 1'b1);
    // Stray byte outside any set.
    send_byte(8'hC3, 1'b0, 1'b1, 8'($urandom));
    // Set that opens and closes inside a two-byte tag.
    set_bytes = '{8'hA5};
    send_set(make_des(TC_TWO, LC_TWO), set_bytes.size(), 1'b1);

    // Random phases; the last one holds the result side off for a while.
    for (ph = 0; ph < 5; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      if (ph == 4) hold_kick = 1'b1;
      stop_at = sent_in_sets + 260;
      while (sent_in_sets < stop_at) random_set();
    end
    in_valid <= 1'b0;

    // Drain, then keep watching for anything spurious to show up.
    waited = 0;
    while (expected_left != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);

    if (mismatches == 0 && expected_left == 0) begin
      $display("klv_local_set_parser_tb: done, clean");
    end else begin
      $display("klv_local_set_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
